FILE: rtl/flcu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flcu_pkg
// Shared types, codes, angle constants and the arctangent table of the
// free-look camera update core.
// ----------------------------------------------------------------------------
package flcu_pkg;

   // widths fixed by the transaction fields
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int ITER_W      = 5;

   // default parameter values
   localparam int DEF_CORDIC_ITERATIONS = 16;
   localparam int DEF_VECTOR_WIDTH      = 16;

   // command codes
   localparam logic [1:0] CMD_MOVE     = 2'd0;
   localparam logic [1:0] CMD_LOOK     = 2'd1;
   localparam logic [1:0] CMD_ZOOM     = 2'd2;
   localparam logic [1:0] CMD_RECENTER = 2'd3;

   // move direction codes
   localparam logic [1:0] DIR_FORWARD  = 2'd0;
   localparam logic [1:0] DIR_BACKWARD = 2'd1;
   localparam logic [1:0] DIR_LEFT     = 2'd2;
   localparam logic [1:0] DIR_RIGHT    = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSITIVITY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_X     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_Y     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_Z     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_YAW   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_PITCH = 3'd6;

   // register reset values
   localparam logic [15:0] SPEED_RESET       = 16'd1280;
   localparam logic [15:0] SENSITIVITY_RESET = 16'd6554;

   // angles in 1/64 degree
   localparam logic signed [17:0] ONE_TURN     = 18'sd23040;
   localparam logic signed [17:0] HALF_TURN    = 18'sd11520;
   localparam logic signed [15:0] HALF_TURN_16 = 16'sd11520;
   localparam logic signed [15:0] QUARTER_TURN = 16'sd5760;
   localparam logic signed [17:0] PITCH_LIMIT  = 18'sd5696;
   localparam logic signed [17:0] ZOOM_MIN     = 18'sd64;
   localparam logic signed [17:0] ZOOM_MAX     = 18'sd2880;
   localparam logic [11:0]        ZOOM_RESET   = 12'd2880;

   // cordic start value (gain compensation), Q2.30
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

   // controller states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MOVE_MUL,
      ST_MOVE_APPLY,
      ST_LOOK_MUL_H,
      ST_LOOK_YAW,
      ST_LOOK_MUL_V,
      ST_LOOK_PITCH,
      ST_ZOOM,
      ST_RECENTER,
      ST_CORDIC_INIT,
      ST_CORDIC_ITER,
      ST_CORDIC_STORE,
      ST_MUL_CC,
      ST_FRONT0,
      ST_DIRECT,
      ST_MUL_SC,
      ST_FRONT2,
      ST_MUL_U0,
      ST_UP0,
      ST_MUL_U1A,
      ST_MUL_U1B,
      ST_UP1,
      ST_MUL_U2,
      ST_UP2,
      ST_PUBLISH
   } ctrl_state_type;

   // datapath operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL,
      OP_MOVE,
      OP_YAW,
      OP_PITCH,
      OP_ZOOM,
      OP_RECENTER,
      OP_CORDIC_INIT,
      OP_CORDIC_ITER,
      OP_CORDIC_STORE,
      OP_FRONT0,
      OP_DIRECT,
      OP_FRONT2,
      OP_UP0,
      OP_UP1,
      OP_UP2,
      OP_PUBLISH
   } dp_op_type;

   // multiplier operand selection
   typedef enum logic [3:0] {
      MUL_MOVE,
      MUL_HOFF,
      MUL_VOFF,
      MUL_CYCP,
      MUL_SYCP,
      MUL_NR2F1,
      MUL_R2F0,
      MUL_R0F2,
      MUL_R0F1
   } mul_sel_type;

   typedef struct packed {
      dp_op_type         op;
      mul_sel_type       mul_sel;
      logic [1:0]        axis;
      logic              ang_sel;
      logic [ITER_W-1:0] iter;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] command;
   } dp_status_type;

   // arctangent of 2^-i in 2^-16 degree
   function automatic logic [21:0] atan_entry(input logic [ITER_W-1:0] idx);
      logic [21:0] v;
      unique case (idx)
         5'd0:    v = 22'd2949120;
         5'd1:    v = 22'd1740967;
         5'd2:    v = 22'd919879;
         5'd3:    v = 22'd466945;
         5'd4:    v = 22'd234379;
         5'd5:    v = 22'd117304;
         5'd6:    v = 22'd58666;
         5'd7:    v = 22'd29335;
         5'd8:    v = 22'd14668;
         5'd9:    v = 22'd7334;
         5'd10:   v = 22'd3667;
         5'd11:   v = 22'd1833;
         5'd12:   v = 22'd917;
         5'd13:   v = 22'd458;
         5'd14:   v = 22'd229;
         5'd15:   v = 22'd115;
         5'd16:   v = 22'd57;
         5'd17:   v = 22'd29;
         5'd18:   v = 22'd14;
         5'd19:   v = 22'd7;
         5'd20:   v = 22'd4;
         5'd21:   v = 22'd2;
         5'd22:   v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

   // fold an angle of at most two turns either way into one turn
   function automatic logic signed [14:0] wrap_turn(input logic signed [17:0] a);
      logic signed [17:0] w;
      w = a;
      if (w >= HALF_TURN) w = w - ONE_TURN;
      if (w >= HALF_TURN) w = w - ONE_TURN;
      if (w < -HALF_TURN) w = w + ONE_TURN;
      if (w < -HALF_TURN) w = w + ONE_TURN;
      return 15'(w);
   endfunction

endpackage

FILE: rtl/flcu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flcu_if
// Channel interfaces of the camera update core: command input, pose
// result and register write.
// ----------------------------------------------------------------------------
interface flcu_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [1:0]         direction;
   logic [15:0]        delta_time;
   logic signed [15:0] horizontal_offset;
   logic signed [15:0] vertical_offset;
   logic               constrain_pitch;

   modport source (output valid, command, direction, delta_time, horizontal_offset,
                   vertical_offset, constrain_pitch, input ready);
   modport sink   (input valid, command, direction, delta_time, horizontal_offset,
                   vertical_offset, constrain_pitch, output ready);
endinterface

interface flcu_rsp_if #(parameter int VECTOR_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [31:0]            pos_x;
   logic signed [31:0]            pos_y;
   logic signed [31:0]            pos_z;
   logic signed [VECTOR_WIDTH-1:0] front_x;
   logic signed [VECTOR_WIDTH-1:0] front_y;
   logic signed [VECTOR_WIDTH-1:0] front_z;
   logic signed [VECTOR_WIDTH-1:0] up_x;
   logic signed [VECTOR_WIDTH-1:0] up_y;
   logic signed [VECTOR_WIDTH-1:0] up_z;
   logic signed [14:0]            yaw_angle;
   logic signed [14:0]            pitch_angle;
   logic [11:0]                   zoom_angle;

   modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                   up_x, up_y, up_z, yaw_angle, pitch_angle, zoom_angle, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                   up_x, up_y, up_z, yaw_angle, pitch_angle, zoom_angle, output ready);
endinterface

interface flcu_csr_if;
   import flcu_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/flcu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flcu_datapath
// Pose state, configuration registers, shared multiplier, iterative cordic
// and the result register, stepped one operation per cycle.
// ----------------------------------------------------------------------------
module flcu_datapath #(
   parameter int VECTOR_WIDTH = flcu_pkg::DEF_VECTOR_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  flcu_pkg::dp_cmd_type           cmd,
   output flcu_pkg::dp_status_type        status,
   // input transaction payload
   input  logic [1:0]                     in_command,
   input  logic [1:0]                     in_direction,
   input  logic [15:0]                    in_delta_time,
   input  logic signed [15:0]             in_horizontal_offset,
   input  logic signed [15:0]             in_vertical_offset,
   input  logic                           in_constrain_pitch,
   // register writes
   input  logic                           csr_write,
   input  logic [flcu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [flcu_pkg::CSR_DATA_W-1:0]  csr_data,
   // result register
   output logic signed [31:0]             res_pos   [3],
   output logic signed [VECTOR_WIDTH-1:0] res_front [3],
   output logic signed [VECTOR_WIDTH-1:0] res_up    [3],
   output logic signed [14:0]             res_yaw,
   output logic signed [14:0]             res_pitch,
   output logic [11:0]                    res_zoom
);
   import flcu_pkg::*;

   localparam int VW       = VECTOR_WIDTH;
   localparam int F        = VW - 2;
   localparam int SH_MOVE  = F + 8;
   localparam int SH_PROD  = 60 - F;
   localparam int SH_VEC   = 30 - F;
   localparam int SH_UP    = F;
   localparam int SH_LOOK  = 16;
   localparam logic signed [66:0]  VONE_W = 67'sd1 <<< F;
   localparam logic signed [VW-1:0] VONE  = VW'(VONE_W);

   // round half up by a constant shift
   function automatic logic signed [66:0] round_shift(input logic signed [66:0] v,
                                                      input int sh);
      return (v + (67'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   // limit to plus or minus one
   function automatic logic signed [VW-1:0] clamp_vec(input logic signed [66:0] v);
      logic signed [66:0] c;
      c = v;
      if (c > VONE_W) c = VONE_W;
      if (c < -VONE_W) c = -VONE_W;
      return VW'(c);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
      logic signed [66:0] c;
      c = v;
      if (c > 67'sd2147483647) c = 67'sd2147483647;
      if (c < -67'sd2147483648) c = -67'sd2147483648;
      return 32'(c);
   endfunction

   // configuration
   logic [15:0]        speed_ff, speed_in;
   logic [15:0]        sens_ff, sens_in;
   logic signed [31:0] start_pos_ff [3];
   logic signed [31:0] start_pos_in [3];
   logic signed [14:0] start_yaw_ff, start_yaw_in;
   logic signed [13:0] start_pitch_ff, start_pitch_in;

   // captured transaction
   logic [1:0]         cmd_ff, cmd_in;
   logic [1:0]         dir_ff, dir_in;
   logic signed [15:0] hoff_ff, hoff_in;
   logic signed [15:0] voff_ff, voff_in;
   logic               constrain_ff, constrain_in;
   logic [31:0]        vel_ff, vel_in;

   // pose
   logic signed [31:0]   pos_ff [3];
   logic signed [31:0]   pos_in [3];
   logic signed [14:0]   yaw_ff, yaw_in;
   logic signed [14:0]   pitch_ff, pitch_in;
   logic [11:0]          zoom_ff, zoom_in;
   logic signed [VW-1:0] front_ff [3];
   logic signed [VW-1:0] front_in [3];
   logic signed [VW-1:0] right_ff [3];
   logic signed [VW-1:0] right_in [3];
   logic signed [VW-1:0] up_ff [3];
   logic signed [VW-1:0] up_in [3];

   // cordic
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [25:0] z_ff, z_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in, sp_ff, sp_in;

   // multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff, prod_in, acc_ff, acc_in;

   // result register
   logic signed [31:0]   out_pos_ff [3];
   logic signed [31:0]   out_pos_in [3];
   logic signed [VW-1:0] out_front_ff [3];
   logic signed [VW-1:0] out_front_in [3];
   logic signed [VW-1:0] out_up_ff [3];
   logic signed [VW-1:0] out_up_in [3];
   logic signed [14:0]   out_yaw_ff, out_yaw_in;
   logic signed [14:0]   out_pitch_ff, out_pitch_in;
   logic [11:0]          out_zoom_ff, out_zoom_in;

   // scratch values
   logic signed [66:0] step_d, step_sum, cpq, r0_w, r2_w;
   logic signed [17:0] ang_sum;
   logic signed [15:0] ang_red;
   logic signed [31:0] cdx, cdy;
   logic signed [25:0] catan;
   logic signed [VW-1:0] r0_v, r2_v;
   logic                 move_sub;

   assign status.command = cmd_ff;

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_sel)
         MUL_MOVE: begin
            mul_a = (dir_ff == DIR_FORWARD || dir_ff == DIR_BACKWARD) ?
                    33'(front_ff[cmd.axis]) : 33'(right_ff[cmd.axis]);
            mul_b = $signed({1'b0, vel_ff});
         end
         MUL_HOFF: begin
            mul_a = 33'(hoff_ff);
            mul_b = 33'($signed({1'b0, sens_ff}));
         end
         MUL_VOFF: begin
            mul_a = 33'(voff_ff);
            mul_b = 33'($signed({1'b0, sens_ff}));
         end
         MUL_CYCP: begin
            mul_a = 33'(cy_ff);
            mul_b = 33'(cp_ff);
         end
         MUL_SYCP: begin
            mul_a = 33'(sy_ff);
            mul_b = 33'(cp_ff);
         end
         MUL_NR2F1: begin
            mul_a = -33'(right_ff[2]);
            mul_b = 33'(front_ff[1]);
         end
         MUL_R2F0: begin
            mul_a = 33'(right_ff[2]);
            mul_b = 33'(front_ff[0]);
         end
         MUL_R0F2: begin
            mul_a = 33'(right_ff[0]);
            mul_b = 33'(front_ff[2]);
         end
         MUL_R0F1: begin
            mul_a = 33'(right_ff[0]);
            mul_b = 33'(front_ff[1]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // next-state logic of the datapath
   always_comb begin
      speed_in       = speed_ff;
      sens_in        = sens_ff;
      start_yaw_in   = start_yaw_ff;
      start_pitch_in = start_pitch_ff;
      cmd_in         = cmd_ff;
      dir_in         = dir_ff;
      hoff_in        = hoff_ff;
      voff_in        = voff_ff;
      constrain_in   = constrain_ff;
      vel_in         = vel_ff;
      yaw_in         = yaw_ff;
      pitch_in       = pitch_ff;
      zoom_in        = zoom_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      neg_in         = neg_ff;
      cy_in          = cy_ff;
      sy_in          = sy_ff;
      cp_in          = cp_ff;
      sp_in          = sp_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      out_yaw_in     = out_yaw_ff;
      out_pitch_in   = out_pitch_ff;
      out_zoom_in    = out_zoom_ff;
      for (int k = 0; k < 3; k++) begin
         start_pos_in[k] = start_pos_ff[k];
         pos_in[k]       = pos_ff[k];
         front_in[k]     = front_ff[k];
         right_in[k]     = right_ff[k];
         up_in[k]        = up_ff[k];
         out_pos_in[k]   = out_pos_ff[k];
         out_front_in[k] = out_front_ff[k];
         out_up_in[k]    = out_up_ff[k];
      end
      move_sub = (dir_ff == DIR_BACKWARD) || (dir_ff == DIR_LEFT);
      step_d   = round_shift(67'(prod_ff), SH_MOVE);
      step_sum = move_sub ? 67'(pos_ff[cmd.axis]) - step_d
                          : 67'(pos_ff[cmd.axis]) + step_d;
      ang_sum  = '0;
      ang_red  = '0;
      cdx      = y_ff >>> cmd.iter;
      cdy      = x_ff >>> cmd.iter;
      catan    = $signed({4'b0, atan_entry(cmd.iter)});
      cpq      = round_shift(67'(cp_ff), SH_VEC);
      r0_w     = round_shift(-67'(sy_ff), SH_VEC);
      r2_w     = round_shift(67'(cy_ff), SH_VEC);
      r0_v     = clamp_vec(r0_w);
      r2_v     = clamp_vec(r2_w);

      // register writes
      if (csr_write) begin
         unique case (csr_index)
            CSR_SPEED:       speed_in = csr_data[15:0];
            CSR_SENSITIVITY: sens_in = csr_data[15:0];
            CSR_START_X:     start_pos_in[0] = $signed(csr_data);
            CSR_START_Y:     start_pos_in[1] = $signed(csr_data);
            CSR_START_Z:     start_pos_in[2] = $signed(csr_data);
            CSR_START_YAW:   start_yaw_in = $signed(csr_data[14:0]);
            CSR_START_PITCH: start_pitch_in = $signed(csr_data[13:0]);
            default: ;
         endcase
      end

      unique case (cmd.op)
         OP_LOAD: begin
            cmd_in       = in_command;
            dir_in       = in_direction;
            hoff_in      = in_horizontal_offset;
            voff_in      = in_vertical_offset;
            constrain_in = in_constrain_pitch;
            vel_in       = speed_ff * in_delta_time;
         end
         OP_MUL: begin
            prod_in = mul_a * mul_b;
            acc_in  = prod_ff;
         end
         OP_MOVE: begin
            pos_in[cmd.axis] = sat32(step_sum);
         end
         OP_YAW: begin
            ang_sum = 18'(yaw_ff) + 18'(round_shift(67'(prod_ff), SH_LOOK));
            yaw_in  = wrap_turn(ang_sum);
         end
         OP_PITCH: begin
            ang_sum = 18'(pitch_ff) + 18'(round_shift(67'(prod_ff), SH_LOOK));
            if (constrain_ff) begin
               if (ang_sum > PITCH_LIMIT) ang_sum = PITCH_LIMIT;
               if (ang_sum < -PITCH_LIMIT) ang_sum = -PITCH_LIMIT;
               pitch_in = 15'(ang_sum);
            end else begin
               pitch_in = wrap_turn(ang_sum);
            end
         end
         OP_ZOOM: begin
            ang_sum = $signed({6'b0, zoom_ff}) - 18'(voff_ff);
            if (ang_sum < ZOOM_MIN) ang_sum = ZOOM_MIN;
            if (ang_sum > ZOOM_MAX) ang_sum = ZOOM_MAX;
            zoom_in = 12'(ang_sum);
         end
         OP_RECENTER: begin
            for (int k = 0; k < 3; k++) pos_in[k] = start_pos_ff[k];
            yaw_in   = wrap_turn(18'(start_yaw_ff));
            pitch_in = 15'(start_pitch_ff);
         end
         OP_CORDIC_INIT: begin
            ang_red = cmd.ang_sel ? 16'(pitch_ff) : 16'(yaw_ff);
            neg_in  = 1'b0;
            if (ang_red > QUARTER_TURN) begin
               ang_red = ang_red - HALF_TURN_16;
               neg_in  = 1'b1;
            end else if (ang_red < -QUARTER_TURN) begin
               ang_red = ang_red + HALF_TURN_16;
               neg_in  = 1'b1;
            end
            z_in = 26'(ang_red) <<< 10;
            x_in = CORDIC_GAIN;
            y_in = '0;
         end
         OP_CORDIC_ITER: begin
            if (z_ff >= 0) begin
               x_in = x_ff - cdx;
               y_in = y_ff + cdy;
               z_in = z_ff - catan;
            end else begin
               x_in = x_ff + cdx;
               y_in = y_ff - cdy;
               z_in = z_ff + catan;
            end
         end
         OP_CORDIC_STORE: begin
            if (cmd.ang_sel) begin
               cp_in = neg_ff ? -x_ff : x_ff;
               sp_in = neg_ff ? -y_ff : y_ff;
            end else begin
               cy_in = neg_ff ? -x_ff : x_ff;
               sy_in = neg_ff ? -y_ff : y_ff;
            end
         end
         OP_FRONT0: front_in[0] = clamp_vec(round_shift(67'(prod_ff), SH_PROD));
         OP_DIRECT: begin
            front_in[1] = clamp_vec(round_shift(67'(sp_ff), SH_VEC));
            // right is held while cos(pitch) rounds to zero
            if (cpq != 0) begin
               right_in[0] = (cpq < 0) ? -r0_v : r0_v;
               right_in[1] = '0;
               right_in[2] = (cpq < 0) ? -r2_v : r2_v;
            end
         end
         OP_FRONT2: front_in[2] = clamp_vec(round_shift(67'(prod_ff), SH_PROD));
         OP_UP0:    up_in[0] = clamp_vec(round_shift(67'(prod_ff), SH_UP));
         OP_UP1:    up_in[1] = clamp_vec(round_shift(67'(acc_ff) - 67'(prod_ff), SH_UP));
         OP_UP2:    up_in[2] = clamp_vec(round_shift(67'(prod_ff), SH_UP));
         OP_PUBLISH: begin
            for (int k = 0; k < 3; k++) begin
               out_pos_in[k]   = pos_ff[k];
               out_front_in[k] = front_ff[k];
               out_up_in[k]    = up_ff[k];
            end
            out_yaw_in   = yaw_ff;
            out_pitch_in = pitch_ff;
            out_zoom_in  = zoom_ff;
         end
         default: ;
      endcase
   end

   // state registers with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff       <= SPEED_RESET;
         sens_ff        <= SENSITIVITY_RESET;
         start_yaw_ff   <= '0;
         start_pitch_ff <= '0;
         yaw_ff         <= '0;
         pitch_ff       <= '0;
         zoom_ff        <= ZOOM_RESET;
         cmd_ff         <= CMD_MOVE;
         for (int k = 0; k < 3; k++) begin
            start_pos_ff[k] <= '0;
            pos_ff[k]       <= '0;
            // front along x, right along z, up along y
            front_ff[k]     <= (k == 0) ? VONE : '0;
            up_ff[k]        <= (k == 1) ? VONE : '0;
            right_ff[k]     <= (k == 2) ? VONE : '0;
         end
      end else begin
         speed_ff       <= speed_in;
         sens_ff        <= sens_in;
         start_yaw_ff   <= start_yaw_in;
         start_pitch_ff <= start_pitch_in;
         yaw_ff         <= yaw_in;
         pitch_ff       <= pitch_in;
         zoom_ff        <= zoom_in;
         cmd_ff         <= cmd_in;
         for (int k = 0; k < 3; k++) begin
            start_pos_ff[k] <= start_pos_in[k];
            pos_ff[k]       <= pos_in[k];
            front_ff[k]     <= front_in[k];
            right_ff[k]     <= right_in[k];
            up_ff[k]        <= up_in[k];
         end
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      dir_ff       <= dir_in;
      hoff_ff      <= hoff_in;
      voff_ff      <= voff_in;
      constrain_ff <= constrain_in;
      vel_ff       <= vel_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      neg_ff       <= neg_in;
      cy_ff        <= cy_in;
      sy_ff        <= sy_in;
      cp_ff        <= cp_in;
      sp_ff        <= sp_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      out_yaw_ff   <= out_yaw_in;
      out_pitch_ff <= out_pitch_in;
      out_zoom_ff  <= out_zoom_in;
      for (int k = 0; k < 3; k++) begin
         out_pos_ff[k]   <= out_pos_in[k];
         out_front_ff[k] <= out_front_in[k];
         out_up_ff[k]    <= out_up_in[k];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         res_pos[k]   = out_pos_ff[k];
         res_front[k] = out_front_ff[k];
         res_up[k]    = out_up_ff[k];
      end
   end
   assign res_yaw   = out_yaw_ff;
   assign res_pitch = out_pitch_ff;
   assign res_zoom  = out_zoom_ff;

endmodule

FILE: rtl/flcu_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flcu_controller
// Sequencer of the camera update: command steps, two cordic runs, vector
// rebuild and hand-off to the result register.
// ----------------------------------------------------------------------------
module flcu_controller #(
   parameter int CORDIC_ITERATIONS = flcu_pkg::DEF_CORDIC_ITERATIONS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output flcu_pkg::dp_cmd_type    cmd,
   input  flcu_pkg::dp_status_type status
);
   import flcu_pkg::*;

   localparam int ITER_CW = $clog2(CORDIC_ITERATIONS);
   localparam logic [ITER_CW-1:0] ITER_LAST = ITER_CW'(CORDIC_ITERATIONS - 1);

   ctrl_state_type     state_ff, state_in;
   logic [1:0]         axis_ff, axis_in;
   logic               ang_sel_ff, ang_sel_in;
   logic [ITER_CW-1:0] iter_ff, iter_in;
   logic               out_valid_ff, out_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         ang_sel_ff   <= 1'b0;
         iter_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         ang_sel_ff   <= ang_sel_in;
         iter_ff      <= iter_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      ang_sel_in   = ang_sel_ff;
      iter_in      = iter_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.mul_sel  = MUL_MOVE;
      cmd.axis     = axis_ff;
      cmd.ang_sel  = ang_sel_ff;
      cmd.iter     = ITER_W'(iter_ff);
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            axis_in    = '0;
            ang_sel_in = 1'b0;
            iter_in    = '0;
            unique case (status.command)
               CMD_MOVE:     state_in = ST_MOVE_MUL;
               CMD_LOOK:     state_in = ST_LOOK_MUL_H;
               CMD_ZOOM:     state_in = ST_ZOOM;
               CMD_RECENTER: state_in = ST_RECENTER;
               default:      state_in = ST_RECENTER;
            endcase
         end
         ST_MOVE_MUL: begin
            cmd.op      = OP_MUL;
            cmd.mul_sel = MUL_MOVE;
            state_in    = ST_MOVE_APPLY;
         end
         ST_MOVE_APPLY: begin
            cmd.op = OP_MOVE;
            if (axis_ff == 2'd2) begin
               state_in = ST_CORDIC_INIT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_MOVE_MUL;
            end
         end
         ST_LOOK_MUL_H: begin
            cmd.op      = OP_MUL;
            cmd.mul_sel = MUL_HOFF;
            state_in    = ST_LOOK_YAW;
         end
         ST_LOOK_YAW: begin
            cmd.op   = OP_YAW;
            state_in = ST_LOOK_MUL_V;
         end
         ST_LOOK_MUL_V: begin
            cmd.op      = OP_MUL;
            cmd.mul_sel = MUL_VOFF;
            state_in    = ST_LOOK_PITCH;
         end
         ST_LOOK_PITCH: begin
            cmd.op   = OP_PITCH;
            state_in = ST_CORDIC_INIT;
         end
         ST_ZOOM: begin
            cmd.op   = OP_ZOOM;
            state_in = ST_CORDIC_INIT;
         end
         ST_RECENTER: begin
            cmd.op   = OP_RECENTER;
            state_in = ST_CORDIC_INIT;
         end
         ST_CORDIC_INIT: begin
            cmd.op   = OP_CORDIC_INIT;
            iter_in  = '0;
            state_in = ST_CORDIC_ITER;
         end
         ST_CORDIC_ITER: begin
            cmd.op = OP_CORDIC_ITER;
            if (iter_ff == ITER_LAST) begin
               state_in = ST_CORDIC_STORE;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         ST_CORDIC_STORE: begin
            cmd.op = OP_CORDIC_STORE;
            if (ang_sel_ff) begin
               state_in = ST_MUL_CC;
            end else begin
               ang_sel_in = 1'b1;
               state_in   = ST_CORDIC_INIT;
            end
         end
         ST_MUL_CC: begin
            cmd.op      = OP_MUL;
            cmd.mul_sel = MUL_CYCP;
            state_in    = ST_FRONT0;
         end
         ST_FRONT0: begin
            cmd.op   = OP_FRONT0;
            state_in = ST_DIRECT;
         end
         ST_DIRECT: begin
            cmd.op   = OP_DIRECT;
            state_in = ST_MUL_SC;
         end
         ST_MUL_SC: begin
            cmd.op      = OP_MUL;
            cmd.mul_sel = MUL_SYCP;
            state_in    = ST_FRONT2;
         end
         ST_FRONT2: begin
            cmd.op   = OP_FRONT2;
            state_in = ST_MUL_U0;
         end
         ST_MUL_U0: begin
            cmd.op      = OP_MUL;
            cmd.mul_sel = MUL_NR2F1;
            state_in    = ST_UP0;
         end
         ST_UP0: begin
            cmd.op   = OP_UP0;
            state_in = ST_MUL_U1A;
         end
         ST_MUL_U1A: begin
            cmd.op      = OP_MUL;
            cmd.mul_sel = MUL_R2F0;
            state_in    = ST_MUL_U1B;
         end
         ST_MUL_U1B: begin
            cmd.op      = OP_MUL;
            cmd.mul_sel = MUL_R0F2;
            state_in    = ST_UP1;
         end
         ST_UP1: begin
            cmd.op   = OP_UP1;
            state_in = ST_MUL_U2;
         end
         ST_MUL_U2: begin
            cmd.op      = OP_MUL;
            cmd.mul_sel = MUL_R0F1;
            state_in    = ST_UP2;
         end
         ST_UP2: begin
            cmd.op   = OP_UP2;
            state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            // wait for the result register to drain
            if (!out_valid_ff || rsp_ready) begin
               cmd.op       = OP_PUBLISH;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = out_valid_ff;

`ifndef SYNTHESIS
   a_accept_dispatch : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_DISPATCH))
      else $error("accepted transaction not dispatched");

   a_iter_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC_ITER) |-> (iter_ff <= ITER_LAST))
      else $error("cordic iteration count overrun");

   a_publish_hold : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUBLISH && out_valid_ff && !rsp_ready)
      |=> (state_ff == ST_PUBLISH && out_valid_ff))
      else $error("result register overwritten before it was taken");
`endif

endmodule

FILE: rtl/free_look_camera_update_core.sv
`timescale 1ns / 1ps
// A new transaction is accepted only after the last result is handed to the result
//   register; the single shared multiplier and the one cordic unit, run once for yaw
//   and once for pitch, serve one transaction at a time.
// Reset: synchronous, active high; pose, vectors and configuration registers return
//   to their start values at once, with no clearing pass.
// ----------------------------------------------------------------------------
// free_look_camera_update_core
// Yaw/pitch free-look camera: applies one command per transaction and
// returns the full pose with rebuilt front and up vectors.
// ----------------------------------------------------------------------------
module free_look_camera_update_core #(
   parameter int CORDIC_ITERATIONS = flcu_pkg::DEF_CORDIC_ITERATIONS,
   parameter int VECTOR_WIDTH      = flcu_pkg::DEF_VECTOR_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   flcu_req_if.sink    req_bus,
   flcu_rsp_if.source  rsp_bus,
   flcu_csr_if.sink    csr_bus
);
   import flcu_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   logic signed [31:0]             res_pos   [3];
   logic signed [VECTOR_WIDTH-1:0] res_front [3];
   logic signed [VECTOR_WIDTH-1:0] res_up    [3];

   // register port always takes a write
   assign csr_bus.ready = 1'b1;

   flcu_controller #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   flcu_datapath #(
      .VECTOR_WIDTH (VECTOR_WIDTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (dp_cmd),
      .status               (dp_status),
      .in_command           (req_bus.command),
      .in_direction         (req_bus.direction),
      .in_delta_time        (req_bus.delta_time),
      .in_horizontal_offset (req_bus.horizontal_offset),
      .in_vertical_offset   (req_bus.vertical_offset),
      .in_constrain_pitch   (req_bus.constrain_pitch),
      .csr_write            (csr_bus.valid),
      .csr_index            (csr_bus.index),
      .csr_data             (csr_bus.data),
      .res_pos              (res_pos),
      .res_front            (res_front),
      .res_up               (res_up),
      .res_yaw              (rsp_bus.yaw_angle),
      .res_pitch            (rsp_bus.pitch_angle),
      .res_zoom             (rsp_bus.zoom_angle)
   );

   // result payload
   assign rsp_bus.pos_x   = res_pos[0];
   assign rsp_bus.pos_y   = res_pos[1];
   assign rsp_bus.pos_z   = res_pos[2];
   assign rsp_bus.front_x = res_front[0];
   assign rsp_bus.front_y = res_front[1];
   assign rsp_bus.front_z = res_front[2];
   assign rsp_bus.up_x    = res_up[0];
   assign rsp_bus.up_y    = res_up[1];
   assign rsp_bus.up_z    = res_up[2];

endmodule
